### src/swm_pkg.sv
// shared constants and types for the sliding window maximum core
// no dependencies
package swm_pkg;

   localparam int WINDOW_MAX_DEFAULT   = 64;
   localparam int SAMPLE_WIDTH_DEFAULT = 32;

   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_ADDR_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH    = 32;
   localparam int WINDOW_SIZE_WIDTH = 7;

   localparam logic [WINDOW_SIZE_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd1;

   // word index of each register on the csr port
   localparam logic REG_WINDOW_SIZE = 1'b0;

   typedef struct packed {
      logic valid;
      logic start;
   } swm_item_ctrl_type;

endpackage

### src/sliding_window_maximum_core.sv
// top level: csr port, input queue, candidate store sequencer and result register
// depends on swm_pkg, swm_front, swm_back (and swm_ram through swm_back)
//
//   channel   handshake            payload
//   input     push / full          req_sample, req_start_of_sequence
//   result    empty / pop          rsp_window_max
//   csr       psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// each sample passes through idle and append, plus a read and a check for each
// candidate inspected at the front (each expired one and the first live one) and for
// each one inspected at the back; this follows from the one read port of the store
// the input queue holds 4 samples, so pushes keep flowing while the store works
// the result register frees in the cycle it is popped; a held result stalls only
// the next sample that produces one
// synchronous active-high reset; store contents need no clearing pass
module sliding_window_maximum_core #(
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [SAMPLE_WIDTH-1:0]              req_sample,
   input  logic                                 req_start_of_sequence,
   output logic                                 empty,
   input  logic                                 pop,
   output logic [SAMPLE_WIDTH-1:0]              rsp_window_max,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [swm_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [swm_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [swm_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);

   logic [swm_pkg::WINDOW_SIZE_WIDTH-1:0] window_size_ff, window_size_in;
   logic                                  csr_write;
   logic                                  csr_hit;
   swm_pkg::swm_item_ctrl_type            item_ctrl;
   logic [SAMPLE_WIDTH-1:0]               item_key;
   logic                                  item_pop;
   logic                                  rsp_valid;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[swm_pkg::CSR_ADDR_WIDTH-1:2] == swm_pkg::REG_WINDOW_SIZE);
   assign csr_write = psel & penable & pwrite & pready;

   assign window_size_in = (csr_write & csr_hit)
                           ? pwdata[swm_pkg::WINDOW_SIZE_WIDTH-1:0] : window_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swm_pkg::WINDOW_SIZE_RESET;
      end else begin
         window_size_ff <= window_size_in;
      end
   end

   assign prdata = csr_hit ? swm_pkg::CSR_DATA_WIDTH'(window_size_ff) : '0;

   swm_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_sample            (req_sample),
      .req_start_of_sequence (req_start_of_sequence),
      .item_ctrl             (item_ctrl),
      .item_key              (item_key),
      .item_pop              (item_pop)
   );

   swm_back #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .window_size (window_size_ff),
      .item_ctrl   (item_ctrl),
      .item_key    (item_key),
      .item_pop    (item_pop),
      .rsp_valid   (rsp_valid),
      .rsp_sample  (rsp_window_max),
      .rsp_pop     (pop)
   );

   assign empty = ~rsp_valid;

   // back end only takes queued beats
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_ctrl.valid)
      else $error("back end took a beat from an empty input queue");

   // a beat taken by the back end frees an input slot
   a_pop_frees_slot: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> !full)
      else $error("input queue still full after a beat was taken");

   // result register is clear right after reset
   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> empty)
      else $error("result pending right after reset");

   // window size changes only through a csr write
   a_window_stable: assert property (@(posedge clock) disable iff (reset)
      !(csr_write && csr_hit) |=> $stable(window_size_ff))
      else $error("window size changed without a csr write");

endmodule

### src/swm_ram.sv
// generic single write port, single read port memory with registered read data
// no dependencies beyond swm_pkg defaults
module swm_ram #(
   parameter int WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int DEPTH = swm_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/swm_front.sv
// input side: takes samples, maps them to unsigned order keys, queues them
// depends on swm_pkg
module swm_front #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [SAMPLE_WIDTH-1:0]           req_sample,
   input  logic                              req_start_of_sequence,
   output swm_pkg::swm_item_ctrl_type        item_ctrl,
   output logic [SAMPLE_WIDTH-1:0]           item_key,
   input  logic                              item_pop
);

   localparam logic [SAMPLE_WIDTH-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

   logic [SAMPLE_WIDTH-1:0]                   key_ff   [swm_pkg::FIFO_DEPTH];
   logic                                      start_ff [swm_pkg::FIFO_DEPTH];
   logic [swm_pkg::FIFO_PTR_WIDTH-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [swm_pkg::FIFO_PTR_WIDTH-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [swm_pkg::FIFO_CNT_WIDTH-1:0]        count_ff, count_in;
   logic                                      accept;
   logic                                      take;

   assign full   = (count_ff == swm_pkg::FIFO_CNT_WIDTH'(swm_pkg::FIFO_DEPTH));
   assign accept = push & ~full;
   assign take   = item_pop & (count_ff != '0);

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + swm_pkg::FIFO_CNT_WIDTH'(accept)
                  - swm_pkg::FIFO_CNT_WIDTH'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (accept) begin
         key_ff[wr_ptr_ff]   <= req_sample ^ SIGN_FLIP;
         start_ff[wr_ptr_ff] <= req_start_of_sequence;
      end
   end

   assign item_ctrl.valid = (count_ff != '0);
   assign item_ctrl.start = start_ff[rd_ptr_ff];
   assign item_key        = key_ff[rd_ptr_ff];

endmodule

### src/swm_back.sv
// back end: monotonic candidate store in a ring buffer, expiry and discard sequencer
// depends on swm_pkg and swm_ram
module swm_back #(
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [swm_pkg::WINDOW_SIZE_WIDTH-1:0]  window_size,
   input  swm_pkg::swm_item_ctrl_type             item_ctrl,
   input  logic [SAMPLE_WIDTH-1:0]                item_key,
   output logic                                   item_pop,
   output logic                                   rsp_valid,
   output logic [SAMPLE_WIDTH-1:0]                rsp_sample,
   input  logic                                   rsp_pop
);

   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int TS_W  = $clog2(WINDOW_MAX) + 1;
   localparam int RAM_W = SAMPLE_WIDTH + TS_W;
   localparam logic [PTR_W-1:0]        PTR_LAST  = PTR_W'(WINDOW_MAX - 1);
   localparam logic [SAMPLE_WIDTH-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRONT_RD,
      ST_FRONT_CHK,
      ST_BACK_RD,
      ST_BACK_CHK,
      ST_APPEND
   } state_type;

   state_type                 state_ff, state_in;
   logic [PTR_W-1:0]          head_ff, head_in;
   logic [PTR_W-1:0]          tail_ff, tail_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          seen_ff, seen_in;
   logic [TS_W-1:0]           now_ff, now_in;
   logic [SAMPLE_WIDTH-1:0]   key_ff, key_in;
   logic [SAMPLE_WIDTH-1:0]   front_ff, front_in;
   logic                      out_valid_ff, out_valid_in;
   logic [SAMPLE_WIDTH-1:0]   out_sample_ff, out_sample_in;

   logic [CNT_W-1:0]          win;
   logic [PTR_W-1:0]          head_next, tail_next, tail_prev;
   logic [CNT_W-1:0]          count_base, seen_base;
   logic [TS_W-1:0]           age;
   logic                      expired;
   logic                      emit;
   logic                      slot_free;
   logic [SAMPLE_WIDTH-1:0]   front_now;

   logic                      ram_we;
   logic [PTR_W-1:0]          ram_raddr;
   logic [RAM_W-1:0]          ram_rdata;
   logic [SAMPLE_WIDTH-1:0]   rd_key;
   logic [TS_W-1:0]           rd_ts;

   swm_ram #(
      .WIDTH (RAM_W),
      .DEPTH (WINDOW_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data ({key_ff, now_ff}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // effective window: zero acts as one, clamp at store depth
   always_comb begin
      if (window_size == '0) begin
         win = CNT_W'(1);
      end else if (32'(window_size) > WINDOW_MAX) begin
         win = CNT_W'(WINDOW_MAX);
      end else begin
         win = CNT_W'(window_size);
      end
   end

   assign head_next = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? PTR_LAST : tail_ff - 1'b1;

   assign rd_key  = ram_rdata[TS_W +: SAMPLE_WIDTH];
   assign rd_ts   = ram_rdata[TS_W-1:0];
   assign age     = now_ff - rd_ts;
   assign expired = (age >= TS_W'(win));

   assign count_base = item_ctrl.start ? '0 : count_ff;
   assign seen_base  = item_ctrl.start ? '0 : seen_ff;
   assign emit       = (seen_ff >= win);
   assign slot_free  = ~out_valid_ff | rsp_pop;
   assign front_now  = (count_ff == '0) ? key_ff : front_ff;

   assign ram_raddr = (state_ff == ST_BACK_RD) ? tail_prev : head_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      seen_in       = seen_ff;
      now_in        = now_ff;
      key_in        = key_ff;
      front_in      = front_ff;
      out_valid_in  = out_valid_ff & ~rsp_pop;
      out_sample_in = out_sample_ff;
      item_pop      = 1'b0;
      ram_we        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (item_ctrl.valid) begin
               item_pop = 1'b1;
               key_in   = item_key;
               now_in   = now_ff + 1'b1;
               count_in = count_base;
               seen_in  = (seen_base < win) ? seen_base + 1'b1 : seen_base;
               if (item_ctrl.start) begin
                  head_in = tail_ff;
               end
               state_in = (count_base != '0) ? ST_FRONT_RD : ST_APPEND;
            end
         end
         ST_FRONT_RD: begin
            state_in = ST_FRONT_CHK;
         end
         ST_FRONT_CHK: begin
            if (expired) begin
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               state_in = (count_ff == CNT_W'(1)) ? ST_APPEND : ST_FRONT_RD;
            end else begin
               front_in = rd_key;
               state_in = ST_BACK_RD;
            end
         end
         ST_BACK_RD: begin
            state_in = ST_BACK_CHK;
         end
         ST_BACK_CHK: begin
            if (rd_key < key_ff) begin
               tail_in  = tail_prev;
               count_in = count_ff - 1'b1;
               state_in = (count_ff == CNT_W'(1)) ? ST_APPEND : ST_BACK_RD;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (~emit | slot_free) begin
               ram_we   = 1'b1;
               tail_in  = tail_next;
               count_in = count_ff + 1'b1;
               front_in = front_now;
               if (emit) begin
                  out_valid_in  = 1'b1;
                  out_sample_in = front_now ^ SIGN_FLIP;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         seen_ff      <= '0;
         now_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         now_ff       <= now_in;
         out_valid_ff <= out_valid_in;
      end
      key_ff        <= key_in;
      front_ff      <= front_in;
      out_sample_ff <= out_sample_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_sample_ff;

endmodule
